// ===== hdl/tset_pkg.sv =====
// ----------------------------------------------------------------------------
// tset_pkg: shared types and codes for the time sorted event table
// Field widths, command and status codes, the stored entry layout and the
// time key that orders entries by hour and then minute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tset_pkg;

	localparam int CMD_W  = 2;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int TAG_W  = 16;
	localparam int SLOT_W = 4;
	localparam int STAT_W = 2;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 5;
	localparam int KEY_W  = HOUR_W + MIN_W;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;

	// Any code other than insert and delete acts as a read.
	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_BADIDX = 2'd2;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// Raw field bits, hour in the upper part, so a plain unsigned compare
	// orders by hour first and minute second.
	function automatic logic [KEY_W-1:0] time_key(entry_t e);
		return {e.hour, e.minute};
	endfunction

endpackage

// ===== hdl/time_sorted_event_table_top.sv =====
// ----------------------------------------------------------------------------
// time_sorted_event_table_top: table of timed entries kept in time order
// A read passes S_RD_CAP and S_DONE on its way to the output register; insert
// and delete also move entries, and refused requests go straight to S_DONE.
// Throughput: one request at a time, bounded by the single RAM port pair.
// Reset clears the entry count and the sequencer; table contents are not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_sorted_event_table_top #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tset_pkg::CMD_W-1:0]    command,
	input  logic [tset_pkg::HOUR_W-1:0]   event_hour,
	input  logic [tset_pkg::MIN_W-1:0]    event_minute,
	input  logic [tset_pkg::TAG_W-1:0]    event_tag,
	input  logic [tset_pkg::SLOT_W-1:0]   slot_index,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [tset_pkg::STAT_W-1:0]   status,
	output logic [tset_pkg::POS_W-1:0]    position,
	output logic [tset_pkg::CNT_W-1:0]    entry_count,
	output logic [tset_pkg::HOUR_W-1:0]   out_hour,
	output logic [tset_pkg::MIN_W-1:0]    out_minute,
	output logic [tset_pkg::TAG_W-1:0]    out_tag
);

	import tset_pkg::*;

	// AW addresses the table, CW holds a count up to DEPTH, CW1 holds a
	// count plus two without wrapping, CMPW compares a request index with
	// the count without losing bits on either side.
	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CW1  = CW + 1;
	localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

	// Sequencer states.
	// S_IDLE     waits for a request and issues the first table read.
	// S_INS_CMP  walks down from the top entry; each later entry is moved
	//            up one slot while the next lower one is read.
	// S_INS_PUT  writes the new entry into slot zero.
	// S_RD_CAP   captures the addressed entry; a delete with entries above it then starts moving.
	// S_DEL_MOV  moves each entry above the removed one down one slot.
	// S_DONE     hands the result to the output register.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_CMP = 3'd1;
	localparam logic [2:0] S_INS_PUT = 3'd2;
	localparam logic [2:0] S_RD_CAP  = 3'd3;
	localparam logic [2:0] S_DEL_MOV = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]     state_q, state_d;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  ptr_q;
	cmd_t           cmd_q;
	entry_t         new_q;
	entry_t         res_q;
	status_t        st_q;
	logic [POS_W-1:0] pos_q;

	// Output register of the result channel.
	logic             res_valid_q;
	status_t          status_q;
	logic [POS_W-1:0] position_q;
	logic [CNT_W-1:0] entry_count_q;
	entry_t           out_entry_q;

	// Table RAM ports.
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [AW-1:0]           ram_raddr;
	logic [$bits(entry_t)-1:0] ram_wdata;
	logic [$bits(entry_t)-1:0] ram_rdata;

	logic   req_take;
	logic   res_free;
	logic   table_full;
	logic   bad_idx;
	logic   ins_later;
	logic   del_more1;
	logic   del_more2;
	entry_t rd_ent;
	entry_t req_ent;
	logic [CW1-1:0] ptr_x;
	logic [CW1-1:0] cnt_x;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;

	// The output register can take a new result when it is empty or when
	// its current result leaves at this edge.
	assign res_free = !res_valid_q || !res_stall;

	assign req_ent = '{hour: event_hour, minute: event_minute, tag: event_tag};
	assign rd_ent  = entry_t'(ram_rdata);

	assign ptr_x = CW1'(ptr_q);
	assign cnt_x = CW1'(count_q);

	assign table_full = (count_q == CW'(DEPTH));
	assign bad_idx    = (CMPW'(slot_index) >= CMPW'(count_q));

	// Equal times keep their arrival order: only strictly later entries
	// are moved above the new one.
	assign ins_later = (time_key(rd_ent) > time_key(new_q));

	// Whether entries remain above the slot being closed.
	assign del_more1 = ((ptr_x + CW1'(1)) < cnt_x);
	assign del_more2 = ((ptr_x + CW1'(2)) < cnt_x);

	tset_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// RAM control and next state. Each cycle of a move both writes the
	// entry just read and reads the next one, so one entry moves per cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q + AW'(1);
		ram_wdata = rd_ent;
		ram_raddr = ptr_q;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (command == CMD_INSERT) begin
					ram_raddr = AW'(count_q - CW'(1));
				end else begin
					ram_raddr = AW'(slot_index);
				end
				if (req_take) begin
					if (command == CMD_INSERT) begin
						if (table_full) begin
							state_d = S_DONE;
						end else if (count_q == '0) begin
							state_d = S_INS_PUT;
						end else begin
							state_d = S_INS_CMP;
						end
					end else if (bad_idx) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD_CAP;
					end
				end
			end
			S_INS_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + AW'(1);
				ram_raddr = ptr_q - AW'(1);
				if (ins_later) begin
					ram_wdata = rd_ent;
					if (ptr_q == '0) begin
						state_d = S_INS_PUT;
					end
				end else begin
					ram_wdata = new_q;
					state_d   = S_DONE;
				end
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = new_q;
				state_d   = S_DONE;
			end
			S_RD_CAP: begin
				ram_raddr = ptr_q + AW'(1);
				if (cmd_q == CMD_DELETE && del_more1) begin
					state_d = S_DEL_MOV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DEL_MOV: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = rd_ent;
				ram_raddr = ptr_q + AW'(2);
				if (!del_more2) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state: sequencer, entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_INS_CMP: begin
					if (!ins_later) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
				end
				S_RD_CAP: begin
					if (cmd_q == CMD_DELETE && !del_more1) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_DEL_MOV: begin
					if (!del_more2) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, walk pointer and the result under construction.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					cmd_q <= command;
					new_q <= req_ent;
					if (command == CMD_INSERT) begin
						ptr_q <= AW'(count_q - CW'(1));
						pos_q <= '0;
						res_q <= req_ent;
						st_q  <= table_full ? ST_FULL : ST_OK;
					end else begin
						ptr_q <= AW'(slot_index);
						pos_q <= POS_W'(slot_index);
						res_q <= '0;
						st_q  <= bad_idx ? ST_BADIDX : ST_OK;
					end
				end
			end
			S_INS_CMP: begin
				ptr_q <= ptr_q - AW'(1);
				if (!ins_later) begin
					pos_q <= POS_W'(ptr_x + CW1'(1));
				end
			end
			S_RD_CAP: begin
				res_q <= rd_ent;
			end
			S_DEL_MOV: begin
				ptr_q <= ptr_q + AW'(1);
			end
			S_DONE: begin
				if (res_free) begin
					status_q      <= st_q;
					position_q    <= pos_q;
					entry_count_q <= CNT_W'(count_q);
					out_entry_q   <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;
	assign out_hour    = out_entry_q.hour;
	assign out_minute  = out_entry_q.minute;
	assign out_tag     = out_entry_q.tag;

	// A taken request always leaves the sequencer busy for the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("sequencer idle right after taking a request");

	// The entry count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	// The insert walk only visits slots that hold valid entries.
	a_ins_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> ptr_x < cnt_x)
		else $error("insert walk pointer beyond valid entries");

	// The count moves only while a request is being worked on.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			$past(state_q) != S_IDLE && $past(state_q) != S_DONE)
		else $error("entry count changed outside a request");

endmodule

// ===== hdl/tset_ram.sv =====
// ----------------------------------------------------------------------------
// tset_ram: generic single write port, single read port RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address. A read of the address being written
// returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tset_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the time sorted event table
// Feeds insert, delete and read requests through the valid/stall request
// channel and compares every result against a behavioral copy of the table
// kept in the bench. A short directed sequence covers the edges first, then
// random traffic runs under three idling profiles and one long result hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import tset_pkg::*;

	localparam int TABLE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 1125;
	// Requests accepted before the idling profile changes.
	localparam int PHASE_ONE_END = 400;
	localparam int PHASE_TWO_END = 800;
	// Long hold-off of the result side, taken once during the quiet phase.
	localparam int HOLD_AT_COUNT = 900;
	localparam int HOLD_CYCLES   = 300;
	// Watchdog limit on cycles in which neither channel moves anything.
	localparam int QUIET_LIMIT   = 2000;
	// Drain margin, sized from the slowest request, which moves every entry.
	localparam int DRAIN_CYCLES  = 3 * (TABLE_DEPTH + 3);
	localparam int MAX_REPORTS   = 10;

	// The package only names insert and delete; everything else reads.
	localparam cmd_t CMD_READ  = 2'd2;
	localparam cmd_t CMD_SPARE = 2'd3;

	typedef struct {
		cmd_t              command;
		entry_t            ent;
		logic [SLOT_W-1:0] slot;
	} table_request_t;

	typedef struct {
		status_t           status;
		logic [POS_W-1:0]  position;
		logic [CNT_W-1:0]  entry_count;
		entry_t            ent;
	} table_result_t;

	// Clock and reset.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// Request channel, driven from the bench. Every input starts at a known value.
	logic              req_valid    = 1'b0;
	logic              req_stall;
	logic [CMD_W-1:0]  command      = '0;
	logic [HOUR_W-1:0] event_hour   = '0;
	logic [MIN_W-1:0]  event_minute = '0;
	logic [TAG_W-1:0]  event_tag    = '0;
	logic [SLOT_W-1:0] slot_index   = '0;

	// Result channel.
	logic              res_valid;
	logic              res_stall    = 1'b0;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  position;
	logic [CNT_W-1:0]  entry_count;
	logic [HOUR_W-1:0] out_hour;
	logic [MIN_W-1:0]  out_minute;
	logic [TAG_W-1:0]  out_tag;

	time_sorted_event_table_top #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.command      (command),
		.event_hour   (event_hour),
		.event_minute (event_minute),
		.event_tag    (event_tag),
		.slot_index   (slot_index),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.position     (position),
		.entry_count  (entry_count),
		.out_hour     (out_hour),
		.out_minute   (out_minute),
		.out_tag      (out_tag)
	);

	// Requests waiting to be offered, and results the table owes us.
	table_request_t pending_requests[$];
	table_result_t  expected_results[$];

	// The bench's own copy of the table contents and fill level.
	entry_t      shadow_slots[TABLE_DEPTH];
	int unsigned shadow_fill = 0;

	// Fill level as seen by the stimulus generator, so that indexes can be
	// aimed at live entries most of the time.
	int unsigned gen_fill = 0;

	int unsigned accepted_requests = 0;
	int unsigned error_count       = 0;
	int unsigned quiet_cycles      = 0;
	logic        req_taken         = 1'b0;
	table_request_t issue_req;

	// Idling profile: the sender idles lightly while the receiver stalls
	// heavily, then the reverse, then neither idles at all.
	int unsigned send_gap_pct;
	int unsigned recv_gap_pct;

	assign send_gap_pct = (accepted_requests < PHASE_ONE_END) ? 33 :
	                      (accepted_requests < PHASE_TWO_END) ? 64 : 0;
	assign recv_gap_pct = (accepted_requests < PHASE_ONE_END) ? 64 :
	                      (accepted_requests < PHASE_TWO_END) ? 33 : 0;

	// Queues one request for the driver and keeps the generator's view of the
	// fill level in step with what the table will do with it.
	task automatic add_request(input cmd_t cmd, input int unsigned hr, input int unsigned mn,
	                           input int unsigned tg, input int unsigned slot);
		table_request_t r;
		r.command    = cmd;
		r.ent.hour   = hr[HOUR_W-1:0];
		r.ent.minute = mn[MIN_W-1:0];
		r.ent.tag    = tg[TAG_W-1:0];
		r.slot       = slot[SLOT_W-1:0];
		pending_requests.push_back(r);
		if (cmd == CMD_INSERT) begin
			if (gen_fill < TABLE_DEPTH)
				gen_fill++;
		end else if (cmd == CMD_DELETE && slot < gen_fill) begin
			gen_fill--;
		end
	endtask

	// Works out the result of one accepted request and updates the shadow
	// table. Entries are ordered by the raw hour bits, then the raw minute
	// bits; a new entry goes after every entry with the same time.
	task automatic predict_table_result(input cmd_t cmd, input entry_t ent,
	                                    input logic [SLOT_W-1:0] slot);
		table_result_t r;
		int unsigned   ins_at;
		int unsigned   i;
		r.ent = ent;
		r.position = '0;
		if (cmd == CMD_INSERT) begin
			if (shadow_fill >= TABLE_DEPTH) begin
				// A full table refuses the entry but echoes it back.
				r.status = ST_FULL;
			end else begin
				ins_at = 0;
				while (ins_at < shadow_fill &&
				       {shadow_slots[ins_at].hour, shadow_slots[ins_at].minute} <=
				       {ent.hour, ent.minute})
					ins_at++;
				for (i = shadow_fill; i > ins_at; i--)
					shadow_slots[i] = shadow_slots[i-1];
				shadow_slots[ins_at] = ent;
				shadow_fill++;
				r.status   = ST_OK;
				r.position = ins_at[POS_W-1:0];
			end
		end else if (slot >= shadow_fill) begin
			// Index past the live entries: nothing moves and the entry is zero.
			r.status   = ST_BADIDX;
			r.position = slot;
			r.ent      = '0;
		end else begin
			r.status   = ST_OK;
			r.position = slot;
			r.ent      = shadow_slots[slot];
			if (cmd == CMD_DELETE) begin
				for (i = slot; i + 1 < shadow_fill; i++)
					shadow_slots[i] = shadow_slots[i+1];
				shadow_fill--;
			end
		end
		r.entry_count = shadow_fill[CNT_W-1:0];
		expected_results.push_back(r);
	endtask

	// Compares the result on the ports with the oldest outstanding one.
	task automatic check_table_result();
		table_result_t want;
		if (expected_results.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: result with nothing outstanding: st=%0d pos=%0d cnt=%0d",
				         $realtime, status, position, entry_count);
		end else begin
			want = expected_results.pop_front();
			if (status !== want.status || position !== want.position ||
			    entry_count !== want.entry_count || out_hour !== want.ent.hour ||
			    out_minute !== want.ent.minute || out_tag !== want.ent.tag) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: mismatch exp st=%0d pos=%0d cnt=%0d %0d:%0d tag=%h, got st=%0d pos=%0d cnt=%0d %0d:%0d tag=%h",
					         $realtime, want.status, want.position, want.entry_count,
					         want.ent.hour, want.ent.minute, want.ent.tag,
					         status, position, entry_count, out_hour, out_minute, out_tag);
			end
		end
	endtask

	// Driver: moves to the next request on the falling edge once the current
	// one has been taken, or inserts an idle cycle at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				issue_req = pending_requests.pop_front();
				req_valid    <= 1'b1;
				command      <= issue_req.command;
				event_hour   <= issue_req.ent.hour;
				event_minute <= issue_req.ent.minute;
				event_tag    <= issue_req.ent.tag;
				slot_index   <= issue_req.slot;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side stall. Once, in the quiet phase, it holds off for a long
	// stretch so that the block keeps a result waiting and stalls its input
	// while the driver keeps offering.
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_requests >= HOLD_AT_COUNT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	// Monitor: on the rising edge, predicts every accepted request, checks
	// every accepted result and runs the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				predict_table_result(command, '{hour: event_hour, minute: event_minute,
				                                tag: event_tag}, slot_index);
				accepted_requests++;
			end
			if (res_valid && !res_stall)
				check_table_result();
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned mode;
		int unsigned roll;
		int unsigned hr;
		int unsigned mn;
		int unsigned slot;
		cmd_t        cmd;

		// Directed part. Reads and deletes on an empty table come first.
		add_request(CMD_READ,   0, 0, 16'h0000, 0);
		add_request(CMD_DELETE, 0, 0, 16'h0000, 15);
		// Sixteen inserts fill the table: earliest and latest legal times,
		// repeated times that must keep arrival order, and field values past
		// the legal hour and minute range, which sort by their raw bits.
		add_request(CMD_INSERT, 12, 30, 16'h1111, 0);
		add_request(CMD_INSERT,  0,  0, 16'h0000, 0);
		add_request(CMD_INSERT, 23, 59, 16'hFFFF, 0);
		add_request(CMD_INSERT, 12, 30, 16'h2222, 0);
		add_request(CMD_INSERT, 31, 63, 16'hA5A5, 0);
		add_request(CMD_INSERT,  0,  0, 16'h5A5A, 0);
		add_request(CMD_INSERT, 12, 30, 16'h3333, 0);
		add_request(CMD_INSERT, 12, 29, 16'h4444, 0);
		add_request(CMD_INSERT, 13,  0, 16'h5555, 0);
		add_request(CMD_INSERT, 11, 59, 16'h6666, 0);
		add_request(CMD_INSERT, 23, 58, 16'h7777, 0);
		add_request(CMD_INSERT,  1,  1, 16'h8888, 0);
		add_request(CMD_INSERT, 22,  0, 16'h9999, 0);
		add_request(CMD_INSERT,  5,  5, 16'hAAAA, 0);
		add_request(CMD_INSERT, 31,  0, 16'hBBBB, 0);
		add_request(CMD_INSERT,  0, 63, 16'hCCCC, 0);
		// A full table refuses the next insert.
		add_request(CMD_INSERT,  6,  6, 16'hBEEF, 0);
		// Last slot, the spare command code, delete at both ends and past it.
		add_request(CMD_READ,   0, 0, 16'h0000, 15);
		add_request(CMD_SPARE,  0, 0, 16'h0000, 7);
		add_request(CMD_DELETE, 0, 0, 16'h0000, 0);
		add_request(CMD_DELETE, 0, 0, 16'h0000, 15);
		add_request(CMD_DELETE, 0, 0, 16'h0000, 14);
		add_request(CMD_READ,   0, 0, 16'h0000, 14);

		// Random part. The traffic drifts between filling, draining and a
		// mix so that the table visits every fill level, full included.
		mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(2);
			roll = $urandom_range(99);
			if (roll < 3)
				cmd = CMD_SPARE;
			else if (mode == 0)
				cmd = (roll < 72) ? CMD_INSERT : (roll < 86) ? CMD_DELETE : CMD_READ;
			else if (mode == 1)
				cmd = (roll < 18) ? CMD_INSERT : (roll < 75) ? CMD_DELETE : CMD_READ;
			else
				cmd = (roll < 42) ? CMD_INSERT : (roll < 72) ? CMD_DELETE : CMD_READ;

			// Mostly legal times, with a narrow set of minutes to force ties,
			// and now and then any bit pattern the fields can hold.
			roll = $urandom_range(9);
			hr = (roll == 0) ? $urandom_range(31) : $urandom_range(23);
			if (roll == 0)
				mn = $urandom_range(63);
			else if (roll < 4)
				mn = 15 * $urandom_range(3);
			else
				mn = $urandom_range(59);

			if (gen_fill > 0 && $urandom_range(9) != 0)
				slot = $urandom_range(gen_fill - 1);
			else
				slot = $urandom_range(15);

			add_request(cmd, hr, mn, $urandom_range(16'hFFFF), slot);
		end

		// Reset is held at the start and released on a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in and every result to come out, then
		// give the block time to show any stray result.
		while (pending_requests.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
